// File: sv/rau_pkg.sv
`default_nettype none
package rau_pkg;

	// sign and magnitude forms of input fields and of full-width products
	typedef struct packed {
		logic        neg;
		logic [31:0] mag;
	} rau_sm32_t;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} rau_sm64_t;

	// reduction request and answer between sequencer and GCD/divide core
	typedef struct packed {
		logic        start;
		logic [63:0] n_mag;
		logic [63:0] d_mag;
	} rau_red_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] nm;
		logic [63:0] dm;
	} rau_red_rsp_t;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_RED = 3'd4;
	localparam logic [2:0] OP_INV = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam rau_sm32_t SM_ZERO = '{neg: 1'b0, mag: 32'd0};
	localparam rau_sm32_t SM_ONE  = '{neg: 1'b0, mag: 32'd1};

	function automatic rau_sm32_t rau_from_field(input logic [31:0] x);
		rau_sm32_t r;
		r.neg = x[31];
		r.mag = x[31] ? (32'd0 - x) : x;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/rau_mul.sv
`default_nettype none
module rau_mul (
	input  wire                 clk,
	input  rau_pkg::rau_sm32_t  x,
	input  rau_pkg::rau_sm32_t  y,
	output rau_pkg::rau_sm64_t  p
);
	import rau_pkg::*;

	logic [63:0] prod;
	rau_sm64_t   p_q;

	assign prod = 64'(x.mag) * 64'(y.mag);

	// product sign is forced positive for a zero magnitude
	always_ff @(posedge clk) begin
		p_q.mag <= prod;
		p_q.neg <= (prod != 64'd0) && (x.neg ^ y.neg);
	end

	assign p = p_q;

endmodule
`default_nettype wire

// File: sv/rau_core.sv
`default_nettype none
module rau_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  rau_pkg::rau_red_req_t  req,
	output rau_pkg::rau_red_rsp_t  rsp
);
	import rau_pkg::*;

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_GCD  = 3'd1;
	localparam logic [2:0] C_DIVN = 3'd2;
	localparam logic [2:0] C_DIVD = 3'd3;
	localparam logic [2:0] C_DONE = 3'd4;

	logic [2:0]  state_q;
	logic [63:0] x_q, y_q, g_q, n_q, d_q, nm_q, dvd_q, rem_q;
	logic [5:0]  k_q, cnt_q;
	logic [64:0] sub_a, sub_b, diff, trial;
	logic        borrow;
	logic        qbit;

	// one shared subtractor: x - y during GCD, trial remainder - g during divide
	assign trial = {rem_q, dvd_q[63]};
	always_comb begin
		if (state_q == C_GCD) begin
			sub_a = {1'b0, x_q};
			sub_b = {1'b0, y_q};
		end else begin
			sub_a = trial;
			sub_b = {1'b0, g_q};
		end
	end
	assign diff   = sub_a - sub_b;
	assign borrow = diff[64];
	assign qbit   = !borrow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			case (state_q)
				C_IDLE: if (req.start) state_q <= C_GCD;
				C_GCD:  if (x_q == 64'd0 || y_q == 64'd0) state_q <= C_DIVN;
				C_DIVN: if (cnt_q == 6'd63) state_q <= C_DIVD;
				C_DIVD: if (cnt_q == 6'd63) state_q <= C_DONE;
				C_DONE: state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				x_q <= req.n_mag;
				y_q <= req.d_mag;
				n_q <= req.n_mag;
				d_q <= req.d_mag;
				k_q <= 6'd0;
			end
			C_GCD: begin
				if (x_q == 64'd0 || y_q == 64'd0) begin
					g_q   <= (x_q | y_q) << k_q;
					dvd_q <= n_q;
					rem_q <= 64'd0;
					cnt_q <= 6'd0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 6'd1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (borrow) begin
					x_q <= y_q;
					y_q <= x_q;
				end else begin
					x_q <= diff[63:0];
				end
			end
			C_DIVN, C_DIVD: begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63 && state_q == C_DIVN) begin
					nm_q  <= {dvd_q[62:0], qbit};
					dvd_q <= d_q;
					rem_q <= 64'd0;
				end else begin
					rem_q <= qbit ? diff[63:0] : trial[63:0];
					dvd_q <= {dvd_q[62:0], qbit};
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = (state_q == C_DONE);
	assign rsp.nm   = nm_q;
	assign rsp.dm   = dvd_q;

endmodule
`default_nettype wire

// File: sv/rational_arith_unit.sv
`default_nettype none
// Channel | Dir | Bits | Contents
// s_*     | in  | 136  | one fraction pair and opcode per beat
// m_*     | out | 72   | one reduced result per beat
//
// An item first runs product/sign setup on the shared 32x32 multiplier,
// then a binary GCD (one compare-subtract, swap or shift a cycle) and two
// restoring divisions on the same 65-bit subtractor, and the result is then
// loaded into the output register.
// A zero denominator skips the GCD and divisions. arst_n clears all control.
// s_tready is high only while idle; a finished result holds in the output
// register until taken, and the next item is accepted meanwhile.
module rational_arith_unit #(
	parameter int WIDTH = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// opcode[2:0], a_numer[34:3], a_denom[66:35], b_numer[98:67],
	// b_denom[130:99], zero fill[135:131]
	input  wire  [135:0] s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// r_numer[31:0], r_denom[62:32], status[64:63], is_zero[65],
	// is_integer[66], zero fill[71:67]
	output logic [71:0]  m_tdata
);
	import rau_pkg::*;

	localparam logic [64:0] HALF = 65'd1 << (WIDTH - 1);

	localparam logic [3:0] T_IDLE = 4'd0;
	localparam logic [3:0] T_M1   = 4'd1;
	localparam logic [3:0] T_M2   = 4'd2;
	localparam logic [3:0] T_M3   = 4'd3;
	localparam logic [3:0] T_M4   = 4'd4;
	localparam logic [3:0] T_ADD  = 4'd5;
	localparam logic [3:0] T_CHK  = 4'd6;
	localparam logic [3:0] T_RED  = 4'd7;
	localparam logic [3:0] T_OUT  = 4'd8;

	logic [3:0]   state_q;
	logic [2:0]   op_q;
	rau_sm32_t    an_q, ad_q, bn_q, bd_q;
	rau_sm32_t    mx, my;
	rau_sm64_t    prod, t1_q, t2_q, dn_q, n_q, t2n;
	logic [71:0]  res_q, out_q;
	logic         out_vld_q;
	logic         neg_q;
	rau_red_req_t req;
	rau_red_rsp_t rsp;
	logic         ovf;
	logic [31:0]  rn;

	rau_mul u_mul (.clk(clk), .x(mx), .y(my), .p(prod));
	rau_core u_core (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// pick multiplier operands: numerator or first cross term, second cross term (add and subtract only), denominator
	always_comb begin
		mx = SM_ZERO;
		my = SM_ZERO;
		case (state_q)
			T_M1: begin
				case (op_q)
					OP_ADD, OP_SUB, OP_DIV: begin mx = an_q; my = bd_q; end
					OP_MUL: begin mx = an_q; my = bn_q; end
					OP_INV: begin mx = ad_q; my = SM_ONE; end
					default: begin mx = an_q; my = SM_ONE; end
				endcase
			end
			T_M2: begin
				if (op_q == OP_ADD || op_q == OP_SUB) begin
					mx = bn_q;
					my = ad_q;
				end
			end
			T_M3: begin
				case (op_q)
					OP_ADD, OP_SUB, OP_MUL: begin mx = ad_q; my = bd_q; end
					OP_DIV: begin mx = ad_q; my = bn_q; end
					OP_INV: begin mx = an_q; my = SM_ONE; end
					default: begin mx = ad_q; my = SM_ONE; end
				endcase
			end
			default: begin
			end
		endcase
	end

	// flip the second term for subtract
	always_comb begin
		t2n = t2_q;
		if (op_q == OP_SUB) t2n.neg = (t2_q.mag != 64'd0) && !t2_q.neg;
	end

	assign req.start = (state_q == T_CHK) && (dn_q.mag != 64'd0);
	assign req.n_mag = n_q.mag;
	assign req.d_mag = dn_q.mag;

	assign ovf = (neg_q ? ({1'b0, rsp.nm} > HALF) : ({1'b0, rsp.nm} > HALF - 65'd1))
		|| ({1'b0, rsp.dm} > HALF - 65'd1);
	assign rn  = neg_q ? (32'd0 - rsp.nm[31:0]) : rsp.nm[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready && state_q != T_OUT) out_vld_q <= 1'b0;
			case (state_q)
				T_IDLE: if (s_tvalid) state_q <= T_M1;
				T_M1:   state_q <= T_M2;
				T_M2:   state_q <= T_M3;
				T_M3:   state_q <= T_M4;
				T_M4:   state_q <= T_ADD;
				T_ADD:  state_q <= T_CHK;
				T_CHK:  state_q <= (dn_q.mag == 64'd0) ? T_OUT : T_RED;
				T_RED:  if (rsp.done) state_q <= T_OUT;
				T_OUT: begin
					// load the result once the output register is free
					if (!out_vld_q || m_tready) begin
						out_vld_q <= 1'b1;
						state_q   <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				op_q <= s_tdata[2:0];
				an_q <= rau_from_field(s_tdata[34:3]);
				ad_q <= rau_from_field(s_tdata[66:35]);
				bn_q <= rau_from_field(s_tdata[98:67]);
				bd_q <= rau_from_field(s_tdata[130:99]);
			end
			T_M2: t1_q <= prod;
			T_M3: t2_q <= prod;
			T_M4: dn_q <= prod;
			T_ADD: begin
				// signed-magnitude sum of the two terms; the second is zero but for add and subtract
				if (t1_q.neg == t2n.neg) begin
					n_q.neg <= t1_q.neg;
					n_q.mag <= t1_q.mag + t2n.mag;
				end else if (t1_q.mag >= t2n.mag) begin
					n_q.neg <= t1_q.neg && (t1_q.mag != t2n.mag);
					n_q.mag <= t1_q.mag - t2n.mag;
				end else begin
					n_q.neg <= t2n.neg;
					n_q.mag <= t2n.mag - t1_q.mag;
				end
			end
			T_CHK: begin
				neg_q <= (n_q.mag != 64'd0) && (n_q.neg != dn_q.neg);
				if (dn_q.mag == 64'd0) res_q <= {5'd0, 1'b0, 1'b0, ST_ZERO_DEN, 31'd0, 32'd0};
			end
			T_RED: begin
				if (rsp.done) begin
					if (ovf) res_q <= {5'd0, 1'b0, 1'b0, ST_OVERFLOW, 31'd0, 32'd0};
					else res_q <= {5'd0, (rsp.dm == 64'd1), (rsp.nm == 64'd0), ST_OK,
						rsp.dm[30:0], rn};
				end
			end
			T_OUT: if (!out_vld_q || m_tready) out_q <= res_q;
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == T_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import rau_pkg::*;

	localparam int NUM_RANDOM  = 1600;
	localparam int SLOW_ITEM   = 420;
	localparam int HOLD_CYCLES = 2000;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] a_numer;
		logic [31:0] a_denom;
		logic [31:0] b_numer;
		logic [31:0] b_denom;
	} frac_op_t;

	// packed from the top bit down, so r_numer sits in the lowest bits
	typedef struct packed {
		logic        is_integer;
		logic        is_zero;
		logic [1:0]  status;
		logic [30:0] r_denom;
		logic [31:0] r_numer;
	} frac_res_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;

	frac_op_t  pending_ops[$];
	frac_res_t expected_results[$];
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	bit        hold_off = 1'b0;
	int        hold_cnt = 0;
	bit        feed_paused = 1'b0;
	int        errors = 0;
	int        beats_in = 0;
	int        beats_out = 0;
	int        zero_den_seen = 0;
	int        overflow_seen = 0;

	rational_arith_unit #(.WIDTH(32)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// sign and 64-bit magnitude of one 32-bit two's complement field
	function automatic logic [64:0] to_sm(input logic [31:0] x);
		logic [63:0] m;
		m = x[31] ? {32'd0, 32'd0 - x} : {32'd0, x};
		return {x[31] && (m != 0), m};
	endfunction

	function automatic logic [64:0] sm_mul(input logic [64:0] x, input logic [64:0] y);
		logic [63:0] m;
		m = x[63:0] * y[63:0];
		return {(m != 0) && (x[64] != y[64]), m};
	endfunction

	function automatic logic [64:0] sm_add(input logic [64:0] x, input logic [64:0] y);
		logic [64:0] r;
		if (x[64] == y[64])
			r = {x[64], x[63:0] + y[63:0]};
		else if (x[63:0] >= y[63:0])
			r = {x[64], x[63:0] - y[63:0]};
		else
			r = {y[64], y[63:0] - x[63:0]};
		if (r[63:0] == 0)
			r[64] = 1'b0;
		return r;
	endfunction

	// reduce the fraction an item describes to lowest terms, with flags
	function automatic frac_res_t reduce_fraction(input frac_op_t op);
		frac_res_t   r;
		logic [64:0] an, ad, bn, bd, n, d;
		logic [63:0] x, y, t, nm, dm;
		logic        neg;
		an = to_sm(op.a_numer);
		ad = to_sm(op.a_denom);
		bn = to_sm(op.b_numer);
		bd = to_sm(op.b_denom);
		case (op.opcode)
			OP_ADD: begin
				n = sm_add(sm_mul(an, bd), sm_mul(bn, ad));
				d = sm_mul(ad, bd);
			end
			OP_SUB: begin
				t = 0;
				n = sm_mul(bn, ad);
				n[64] = (n[63:0] != 0) && !n[64];
				n = sm_add(sm_mul(an, bd), n);
				d = sm_mul(ad, bd);
			end
			OP_MUL: begin
				n = sm_mul(an, bn);
				d = sm_mul(ad, bd);
			end
			OP_DIV: begin
				n = sm_mul(an, bd);
				d = sm_mul(ad, bn);
			end
			OP_INV: begin
				n = ad;
				d = an;
			end
			default: begin
				n = an;
				d = ad;
			end
		endcase
		r = '0;
		if (d[63:0] == 0) begin
			r.status = ST_ZERO_DEN;
			return r;
		end
		neg = (n[63:0] != 0) && (n[64] != d[64]);
		x = n[63:0];
		y = d[63:0];
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		nm = n[63:0] / x;
		dm = d[63:0] / x;
		if ((neg ? (nm > 64'h8000_0000) : (nm > 64'h7fff_ffff)) || dm > 64'h7fff_ffff) begin
			r.status = ST_OVERFLOW;
			return r;
		end
		r.r_numer = neg ? 32'(64'd0 - nm) : nm[31:0];
		r.r_denom = dm[30:0];
		r.status = ST_OK;
		r.is_zero = (nm == 0);
		r.is_integer = (dm == 1);
		return r;
	endfunction

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 32'($signed($urandom_range(0, 24)) - 12);
			1: return 32'($signed($urandom_range(0, 2000)) - 1000);
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
			3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic frac_op_t rand_op();
		frac_op_t op;
		op.opcode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		op.a_numer = rand_field();
		op.a_denom = rand_field();
		op.b_numer = rand_field();
		op.b_denom = rand_field();
		// keep most denominators nonzero so results are mostly reducible
		if (op.a_denom == 0 && $urandom_range(0, 3) != 0) op.a_denom = 32'd7;
		if (op.b_denom == 0 && $urandom_range(0, 3) != 0) op.b_denom = 32'hffff_fffd;
		return op;
	endfunction

	function automatic frac_op_t mk(input logic [2:0] oc, input int an, input int ad,
			input int bn, input int bd);
		frac_op_t op;
		op.opcode = oc;
		op.a_numer = an;
		op.a_denom = ad;
		op.b_numer = bn;
		op.b_denom = bd;
		return op;
	endfunction

	// driver: advance to the next pending beat once the current one is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (s_tvalid && s_tready)
					beats_in <= beats_in + 1;
				if (pending_ops.size() != 0 && !feed_paused &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					s_tdata <= {5'd0, pending_ops[0].b_denom, pending_ops[0].b_numer,
						pending_ops[0].a_denom, pending_ops[0].a_numer, pending_ops[0].opcode};
					expected_results.push_back(reduce_fraction(pending_ops.pop_front()));
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure; a hold-off stretch is counted here
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_off && hold_cnt < HOLD_CYCLES) begin
				hold_cnt <= hold_cnt + 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		frac_res_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[66:0];
			beats_out <= beats_out + 1;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors <= errors + 1;
			end else begin
				exp_r = expected_results.pop_front();
				if (got.status == ST_ZERO_DEN) zero_den_seen <= zero_den_seen + 1;
				if (got.status == ST_OVERFLOW) overflow_seen <= overflow_seen + 1;
				if (got !== exp_r) begin
					$display("%0t: mismatch expected num=%0d den=%0d st=%0d z=%0b i=%0b",
						$time, $signed(exp_r.r_numer), exp_r.r_denom, exp_r.status,
						exp_r.is_zero, exp_r.is_integer);
					$display("%0t:          actual   num=%0d den=%0d st=%0d z=%0b i=%0b",
						$time, $signed(got.r_numer), got.r_denom, got.status,
						got.is_zero, got.is_integer);
					errors <= errors + 1;
				end
			end
		end
	end

	task automatic drain();
		while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) pending_ops.push_back(rand_op());
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every opcode, field extremes, zero denominators, overflow
		pending_ops.push_back(mk(OP_ADD, 1, 2, 1, 3));
		pending_ops.push_back(mk(OP_SUB, 1, 2, 1, 2));
		pending_ops.push_back(mk(OP_MUL, -6, 4, 2, -9));
		pending_ops.push_back(mk(OP_DIV, 3, 5, -6, 10));
		pending_ops.push_back(mk(OP_RED, 12, -18, 0, 0));
		pending_ops.push_back(mk(OP_INV, -3, 7, 0, 0));
		pending_ops.push_back(mk(OP_RED, 5, 0, 1, 1));
		pending_ops.push_back(mk(OP_DIV, 1, 2, 0, 5));
		pending_ops.push_back(mk(OP_INV, 0, 9, 1, 1));
		pending_ops.push_back(mk(OP_ADD, 0, -5, 0, 3));
		pending_ops.push_back(mk(OP_RED, 32'h8000_0000, 1, 0, 0));
		pending_ops.push_back(mk(OP_RED, 32'h8000_0000, -1, 0, 0));
		pending_ops.push_back(mk(OP_INV, 1, 32'h8000_0000, 0, 0));
		pending_ops.push_back(mk(OP_INV, -1, 32'h8000_0000, 0, 0));
		pending_ops.push_back(mk(OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
		pending_ops.push_back(mk(OP_MUL, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000));
		pending_ops.push_back(mk(OP_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 1, 32'h7fff_fffd));
		pending_ops.push_back(mk(OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1));
		pending_ops.push_back(mk(3'd6, -10, 4, 1, 1));
		pending_ops.push_back(mk(3'd7, 10, -4, 1, 1));
		pending_ops.push_back(mk(OP_DIV, 32'h8000_0000, 1, -1, 1));
		drain();

		run_phase(0, 0, 300);
		run_phase(63, 0, 300);
		run_phase(0, 63, 300);

		// long receiver hold-off while the sender keeps offering
		hold_off = 1'b1;
		repeat (20) pending_ops.push_back(rand_op());
		wait (hold_cnt == HOLD_CYCLES);
		hold_off = 1'b0;
		drain();

		// sender pauses while items are queued, then resumes
		feed_paused = 1'b1;
		repeat (10) pending_ops.push_back(rand_op());
		repeat (5) @(posedge clk);
		feed_paused = 1'b0;
		drain();

		run_phase(13, 13, 300);
		run_phase(0, 0, NUM_RANDOM - 1230);

		repeat (SLOW_ITEM) @(posedge clk);
		$display("Sent %0d fraction beats, got %0d results (%0d zero-denominator, %0d overflow)",
			beats_in, beats_out, zero_den_seen, overflow_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#60ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
